// ===== rtl/belt_pkg.sv =====
// Package: BelT S-box, G function, round types and key-length codes.
`timescale 1ns / 1ps
package belt_pkg;

    localparam int unsigned NumRounds = 8;
    localparam int unsigned StepsPerRound = 7;

    typedef enum logic [1:0] {
        t_KEY_128 = 2'd0,
        t_KEY_192 = 2'd1,
        t_KEY_256 = 2'd2,
        t_KEY_RSV = 2'd3
    } t_key_len;

    typedef enum logic [2:0] {
        CFG_KEY_12  = 3'd0,
        CFG_KEY_34  = 3'd1,
        CFG_KEY_56  = 3'd2,
        CFG_KEY_78  = 3'd3,
        CFG_KEY_LEN = 3'd4
    } t_cfg_index;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef struct packed {
        logic        valid;
        logic        op;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } t_stage;

    localparam logic [7:0] SBOX [256] = '{
        8'hB1,8'h94,8'hBA,8'hC8,8'h0A,8'h08,8'hF5,8'h3B,8'h36,8'h6D,8'h00,8'h8E,8'h58,8'h4A,8'h5D,8'hE4,
        8'h85,8'h04,8'hFA,8'h9D,8'h1B,8'hB6,8'hC7,8'hAC,8'h25,8'h2E,8'h72,8'hC2,8'h02,8'hFD,8'hCE,8'h0D,
        8'h5B,8'hE3,8'hD6,8'h12,8'h17,8'hB9,8'h61,8'h81,8'hFE,8'h67,8'h86,8'hAD,8'h71,8'h6B,8'h89,8'h0B,
        8'h5C,8'hB0,8'hC0,8'hFF,8'h33,8'hC3,8'h56,8'hB8,8'h35,8'hC4,8'h05,8'hAE,8'hD8,8'hE0,8'h7F,8'h99,
        8'hE1,8'h2B,8'hDC,8'h1A,8'hE2,8'h82,8'h57,8'hEC,8'h70,8'h3F,8'hCC,8'hF0,8'h95,8'hEE,8'h8D,8'hF1,
        8'hC1,8'hAB,8'h76,8'h38,8'h9F,8'hE6,8'h78,8'hCA,8'hF7,8'hC6,8'hF8,8'h60,8'hD5,8'hBB,8'h9C,8'h4F,
        8'hF3,8'h3C,8'h65,8'h7B,8'h63,8'h7C,8'h30,8'h6A,8'hDD,8'h4E,8'hA7,8'h79,8'h9E,8'hB2,8'h3D,8'h31,
        8'h3E,8'h98,8'hB5,8'h6E,8'h27,8'hD3,8'hBC,8'hCF,8'h59,8'h1E,8'h18,8'h1F,8'h4C,8'h5A,8'hB7,8'h93,
        8'hE9,8'hDE,8'hE7,8'h2C,8'h8F,8'h0C,8'h0F,8'hA6,8'h2D,8'hDB,8'h49,8'hF4,8'h6F,8'h73,8'h96,8'h47,
        8'h06,8'h07,8'h53,8'h16,8'hED,8'h24,8'h7A,8'h37,8'h39,8'hCB,8'hA3,8'h83,8'h03,8'hA9,8'h8B,8'hF6,
        8'h92,8'hBD,8'h9B,8'h1C,8'hE5,8'hD1,8'h41,8'h01,8'h54,8'h45,8'hFB,8'hC9,8'h5E,8'h4D,8'h0E,8'hF2,
        8'h68,8'h20,8'h80,8'hAA,8'h22,8'h7D,8'h64,8'h2F,8'h26,8'h87,8'hF9,8'h34,8'h90,8'h40,8'h55,8'h11,
        8'hBE,8'h32,8'h97,8'h13,8'h43,8'hFC,8'h9A,8'h48,8'hA0,8'h2A,8'h88,8'h5F,8'h19,8'h4B,8'h09,8'hA1,
        8'h7E,8'hCD,8'hA4,8'hD0,8'h15,8'h44,8'hAF,8'h8C,8'hA5,8'h84,8'h50,8'hBF,8'h66,8'hD2,8'hE8,8'h8A,
        8'hA2,8'hD7,8'h46,8'h52,8'h42,8'hA8,8'hDF,8'hB3,8'h69,8'h74,8'hC5,8'h51,8'hEB,8'h23,8'h29,8'h21,
        8'hD4,8'hEF,8'hD9,8'hB4,8'h3A,8'h62,8'h28,8'h75,8'h91,8'h14,8'h10,8'hEA,8'h77,8'h6C,8'hDA,8'h1D
    };

    function automatic logic [31:0] gfun(input logic [31:0] u, input logic [4:0] rot);
        logic [31:0] s;
        logic [63:0] w;
        s = {SBOX[u[31:24]], SBOX[u[23:16]], SBOX[u[15:8]], SBOX[u[7:0]]};
        w = {s, s} << rot;
        return w[63:32];
    endfunction

endpackage

// ===== rtl/belt_block_cipher_unit.sv =====
// BelT block cipher top level: key registers and a 57-stage round pipeline.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------------------------
//  in      | i_valid   | o_stall   | i_opcode, i_block_low, i_block_high
//  out     | o_valid   | i_stall   | o_result_low, o_result_high
//  config  | i_cfg_we  | -         | i_cfg_index, i_cfg_data
//
// One block enters per cycle while the input is not stalled. A block passes
// an entry register, then one register stage for each of the 56 round steps
// (one G function plus its add or xor), the last of which drives the outputs.
// The whole pipeline advances together: a stall at the output freezes every
// stage, and the input is stalled only when the output is held full. Reset
// (synchronous) clears the valid bits and loads the key registers with zero
// words and the 256-bit mode.
`timescale 1ns / 1ps
module belt_block_cipher_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [63:0] i_block_low,
    input  logic [63:0] i_block_high,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_result_low,
    output logic [63:0] o_result_high,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import belt_pkg::*;

    localparam int unsigned NumSteps = NumRounds * StepsPerRound;

    logic [63:0] r_key12, r_key34, r_key56, r_key78;
    logic [1:0]  r_klen;
    logic [31:0] th [8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key12 <= '0;
            r_key34 <= '0;
            r_key56 <= '0;
            r_key78 <= '0;
            r_klen  <= t_KEY_256;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_12:  r_key12 <= i_cfg_data;
                CFG_KEY_34:  r_key34 <= i_cfg_data;
                CFG_KEY_56:  r_key56 <= i_cfg_data;
                CFG_KEY_78:  r_key78 <= i_cfg_data;
                CFG_KEY_LEN: r_klen  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        th[0] = r_key12[31:0];
        th[1] = r_key12[63:32];
        th[2] = r_key34[31:0];
        th[3] = r_key34[63:32];
        th[4] = r_key56[31:0];
        th[5] = r_key56[63:32];
        th[6] = r_key78[31:0];
        th[7] = r_key78[63:32];
        case (r_klen)
            t_KEY_128: begin
                th[4] = th[0]; th[5] = th[1]; th[6] = th[2]; th[7] = th[3];
            end
            t_KEY_192: begin
                th[6] = r_key12[31:0] ^ r_key12[63:32] ^ r_key34[31:0];
                th[7] = r_key34[63:32] ^ r_key56[31:0] ^ r_key56[63:32];
            end
            default: ;
        endcase
    end

    // Whole pipe moves unless the output holds a result that is stalled.
    logic   advance;
    t_stage r_st [NumSteps + 1];
    t_stage n_st [NumSteps + 1];

    assign advance = !(r_st[NumSteps].valid && i_stall);
    assign o_stall = !advance;

    always_comb begin
        n_st[0].valid = i_valid;
        n_st[0].op    = i_opcode;
        n_st[0].a     = i_block_low[31:0];
        n_st[0].b     = i_block_low[63:32];
        n_st[0].c     = i_block_high[31:0];
        n_st[0].d     = i_block_high[63:32];
        n_st[0].e     = '0;
        for (int s = 0; s < NumSteps; s++) begin
            automatic int          rnd   = s / 7;
            automatic int          k     = s % 7;
            automatic logic [31:0] rid;
            automatic logic [2:0]  kenc;
            automatic logic [2:0]  kdec;
            automatic logic [31:0] rk;
            automatic t_stage      x;
            automatic t_stage      y;
            x = r_st[s];
            y = x;
            rid  = 32'(rnd + 1);
            kenc = 3'((7 * (rnd + 1) - 6 + k - 1) & 7);
            kdec = 3'((7 * (NumRounds - rnd) - k - 1) & 7);
            rk = (x.op == OP_DECRYPT) ? th[kdec] : th[kenc];
            if (x.op == OP_DECRYPT) begin
                rid = 32'(NumRounds - rnd);
            end
            case (k)
                0: y.b = x.b ^ gfun(x.a + rk, 5'd5);
                1: y.c = x.c ^ gfun(x.d + rk, 5'd21);
                2: y.a = x.a - gfun(x.b + rk, 5'd13);
                3: begin
                    y.e = gfun(x.b + x.c + rk, 5'd21) ^ rid;
                    y.b = x.b + y.e;
                    y.c = x.c - y.e;
                end
                4: y.d = x.d + gfun(x.c + rk, 5'd13);
                5: y.b = x.b ^ gfun(x.a + rk, 5'd21);
                default: begin
                    y.c = x.c ^ gfun(x.d + rk, 5'd5);
                    // apply the round's word permutation
                    if (x.op == OP_DECRYPT) begin
                        y.a = y.c; y.b = x.a; y.c = x.d; y.d = x.b;
                    end else begin
                        y.d = y.c; y.a = x.b; y.b = x.d; y.c = x.a;
                    end
                end
            endcase
            n_st[s + 1] = y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NumSteps; s++) begin
                r_st[s].valid <= 1'b0;
            end
        end else if (advance) begin
            for (int s = 0; s <= NumSteps; s++) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    // Output order: encrypt b,d,a,c ; decrypt c,a,d,b (after last swap).
    logic [31:0] w0, w1, w2, w3;
    always_comb begin
        if (r_st[NumSteps].op == OP_DECRYPT) begin
            w0 = r_st[NumSteps].c; w1 = r_st[NumSteps].a;
            w2 = r_st[NumSteps].d; w3 = r_st[NumSteps].b;
        end else begin
            w0 = r_st[NumSteps].b; w1 = r_st[NumSteps].d;
            w2 = r_st[NumSteps].a; w3 = r_st[NumSteps].c;
        end
    end

    assign o_valid       = r_st[NumSteps].valid;
    assign o_result_low  = {w1, w0};
    assign o_result_high = {w3, w2};

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_low) && $stable(o_result_high))
        else $error("result changed while stalled");
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with free output");
    a_pipe_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall && i_valid |=> r_st[0].valid)
        else $error("accepted transfer lost at entry");
    a_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_st[0].valid))
        else $error("entry stage moved during stall");

endmodule

// ===== tb/belt_block_cipher_unit_tb.sv =====
// Testbench for the BelT block cipher unit: self-checking against an in-bench cipher predictor.
`timescale 1ns / 1ps
module belt_block_cipher_unit_tb;
    import belt_pkg::*;

    localparam int unsigned FlushCycles = 70;
    localparam int unsigned CycleLimit = 400000;
    localparam logic [2:0] CFG_SPARE_5 = 3'd5;
    localparam logic [2:0] CFG_SPARE_6 = 3'd6;
    localparam logic [2:0] CFG_SPARE_7 = 3'd7;

    localparam logic [7:0] HBOX [256] = '{
        8'hB1,8'h94,8'hBA,8'hC8,8'h0A,8'h08,8'hF5,8'h3B,8'h36,8'h6D,8'h00,8'h8E,8'h58,8'h4A,8'h5D,8'hE4,
        8'h85,8'h04,8'hFA,8'h9D,8'h1B,8'hB6,8'hC7,8'hAC,8'h25,8'h2E,8'h72,8'hC2,8'h02,8'hFD,8'hCE,8'h0D,
        8'h5B,8'hE3,8'hD6,8'h12,8'h17,8'hB9,8'h61,8'h81,8'hFE,8'h67,8'h86,8'hAD,8'h71,8'h6B,8'h89,8'h0B,
        8'h5C,8'hB0,8'hC0,8'hFF,8'h33,8'hC3,8'h56,8'hB8,8'h35,8'hC4,8'h05,8'hAE,8'hD8,8'hE0,8'h7F,8'h99,
        8'hE1,8'h2B,8'hDC,8'h1A,8'hE2,8'h82,8'h57,8'hEC,8'h70,8'h3F,8'hCC,8'hF0,8'h95,8'hEE,8'h8D,8'hF1,
        8'hC1,8'hAB,8'h76,8'h38,8'h9F,8'hE6,8'h78,8'hCA,8'hF7,8'hC6,8'hF8,8'h60,8'hD5,8'hBB,8'h9C,8'h4F,
        8'hF3,8'h3C,8'h65,8'h7B,8'h63,8'h7C,8'h30,8'h6A,8'hDD,8'h4E,8'hA7,8'h79,8'h9E,8'hB2,8'h3D,8'h31,
        8'h3E,8'h98,8'hB5,8'h6E,8'h27,8'hD3,8'hBC,8'hCF,8'h59,8'h1E,8'h18,8'h1F,8'h4C,8'h5A,8'hB7,8'h93,
        8'hE9,8'hDE,8'hE7,8'h2C,8'h8F,8'h0C,8'h0F,8'hA6,8'h2D,8'hDB,8'h49,8'hF4,8'h6F,8'h73,8'h96,8'h47,
        8'h06,8'h07,8'h53,8'h16,8'hED,8'h24,8'h7A,8'h37,8'h39,8'hCB,8'hA3,8'h83,8'h03,8'hA9,8'h8B,8'hF6,
        8'h92,8'hBD,8'h9B,8'h1C,8'hE5,8'hD1,8'h41,8'h01,8'h54,8'h45,8'hFB,8'hC9,8'h5E,8'h4D,8'h0E,8'hF2,
        8'h68,8'h20,8'h80,8'hAA,8'h22,8'h7D,8'h64,8'h2F,8'h26,8'h87,8'hF9,8'h34,8'h90,8'h40,8'h55,8'h11,
        8'hBE,8'h32,8'h97,8'h13,8'h43,8'hFC,8'h9A,8'h48,8'hA0,8'h2A,8'h88,8'h5F,8'h19,8'h4B,8'h09,8'hA1,
        8'h7E,8'hCD,8'hA4,8'hD0,8'h15,8'h44,8'hAF,8'h8C,8'hA5,8'h84,8'h50,8'hBF,8'h66,8'hD2,8'hE8,8'h8A,
        8'hA2,8'hD7,8'h46,8'h52,8'h42,8'hA8,8'hDF,8'hB3,8'h69,8'h74,8'hC5,8'h51,8'hEB,8'h23,8'h29,8'h21,
        8'hD4,8'hEF,8'hD9,8'hB4,8'h3A,8'h62,8'h28,8'h75,8'h91,8'h14,8'h10,8'hEA,8'h77,8'h6C,8'hDA,8'h1D
    };

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } t_block;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_stall;
    logic        in_opcode = OP_ENCRYPT;
    logic [63:0] in_low = '0;
    logic [63:0] in_high = '0;
    logic        o_valid;
    logic        out_stall = 1'b0;
    logic [63:0] o_result_low;
    logic [63:0] o_result_high;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = CFG_KEY_12;
    logic [63:0] cfg_data = '0;

    belt_block_cipher_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .o_stall(o_stall),
        .i_opcode(in_opcode), .i_block_low(in_low), .i_block_high(in_high),
        .o_valid(o_valid), .i_stall(out_stall),
        .o_result_low(o_result_low), .o_result_high(o_result_high),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the key registers
    logic [63:0] key_12 = '0, key_34 = '0, key_56 = '0, key_78 = '0;
    t_key_len    key_mode = t_KEY_256;

    t_block      cipher_fifo[$];
    int unsigned mismatches = 0;
    int unsigned blocks_sent = 0;
    int unsigned blocks_seen = 0;
    int unsigned cycle_count = 0;
    bit          idle_on = 1'b0;
    int          hold_left = 0;
    int          burst_left = 0;

    function automatic logic [31:0] g_word(logic [31:0] u, int unsigned r);
        logic [31:0] s;
        s = {HBOX[u[31:24]], HBOX[u[23:16]], HBOX[u[15:8]], HBOX[u[7:0]]};
        return (s << r) | (s >> (32 - r));
    endfunction

    function automatic t_block belt_crypt(logic op, logic [63:0] lo, logic [63:0] hi);
        logic [31:0] th [8];
        logic [31:0] a, b, c, d, e, t;
        t_block      res;
        th[0] = key_12[31:0]; th[1] = key_12[63:32];
        th[2] = key_34[31:0]; th[3] = key_34[63:32];
        th[4] = key_56[31:0]; th[5] = key_56[63:32];
        th[6] = key_78[31:0]; th[7] = key_78[63:32];
        if (key_mode == t_KEY_128) begin
            for (int k = 0; k < 4; k++) th[k + 4] = th[k];
        end else if (key_mode == t_KEY_192) begin
            th[6] = th[0] ^ th[1] ^ th[2];
            th[7] = th[3] ^ th[4] ^ th[5];
        end
        a = lo[31:0]; b = lo[63:32]; c = hi[31:0]; d = hi[63:32];
        // round key n (1..56) is th[(n-1) mod 8]
        if (op == OP_ENCRYPT) begin
            for (int i = 1; i <= 8; i++) begin
                b ^= g_word(a + th[(7*i - 7) & 7], 5);
                c ^= g_word(d + th[(7*i - 6) & 7], 21);
                a -= g_word(b + th[(7*i - 5) & 7], 13);
                e = g_word(b + c + th[(7*i - 4) & 7], 21) ^ 32'(i);
                b += e;
                c -= e;
                d += g_word(c + th[(7*i - 3) & 7], 13);
                b ^= g_word(a + th[(7*i - 2) & 7], 21);
                c ^= g_word(d + th[(7*i - 1) & 7], 5);
                t = a; a = b; b = t;
                t = c; c = d; d = t;
                t = b; b = c; c = t;
            end
            res.lo = {d, b};
            res.hi = {c, a};
        end else begin
            for (int i = 8; i >= 1; i--) begin
                b ^= g_word(a + th[(7*i - 1) & 7], 5);
                c ^= g_word(d + th[(7*i - 2) & 7], 21);
                a -= g_word(b + th[(7*i - 3) & 7], 13);
                e = g_word(b + c + th[(7*i - 4) & 7], 21) ^ 32'(i);
                b += e;
                c -= e;
                d += g_word(c + th[(7*i - 5) & 7], 13);
                b ^= g_word(a + th[(7*i - 6) & 7], 21);
                c ^= g_word(d + th[(7*i - 7) & 7], 5);
                t = a; a = b; b = t;
                t = c; c = d; d = t;
                t = a; a = d; d = t;
            end
            res.lo = {a, c};
            res.hi = {b, d};
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     cipher_fifo.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // output stall: a long hold-off when one is requested, else random bursts while idle_on is set
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else if (burst_left > 0) begin
            out_stall <= 1'b1;
            burst_left = burst_left - 1;
        end else if (idle_on && ($urandom_range(0, 7) == 0)) begin
            out_stall <= 1'b1;
            burst_left = $urandom_range(0, 10);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // sample mid-cycle; the transfer happens at the next rising edge
    always @(negedge i_clk) begin
        t_block want;
        if (i_rst_n && o_valid && !out_stall) begin
            blocks_seen++;
            if (cipher_fifo.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h %h", o_result_high, o_result_low);
            end else begin
                want = cipher_fifo.pop_front();
                if (o_result_low !== want.lo || o_result_high !== want.hi) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h %h, got %h %h", want.hi, want.lo,
                                 o_result_high, o_result_low);
                end
            end
        end
    end

    // called at a rising edge; returns at the edge where the block transferred
    task automatic send_block(logic op, logic [63:0] lo, logic [63:0] hi);
        bit     taken;
        t_block want;
        if (idle_on && ($urandom_range(0, 3) == 0)) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        want = belt_crypt(op, lo, hi);
        in_valid  <= 1'b1;
        in_opcode <= op;
        in_low    <= lo;
        in_high   <= hi;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end
        cipher_fifo = {cipher_fifo, want};
        blocks_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (cipher_fifo.size() != 0) @(posedge i_clk);
        repeat (FlushCycles) @(posedge i_clk);
    endtask

    // leaves the write enable high; the caller drops it after the last write
    task automatic cfg_write(logic [2:0] idx, logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_KEY_12:  key_12 = data;
            CFG_KEY_34:  key_34 = data;
            CFG_KEY_56:  key_56 = data;
            CFG_KEY_78:  key_78 = data;
            CFG_KEY_LEN: key_mode = t_key_len'(data[1:0]);
            default: ;
        endcase
    endtask

    task automatic set_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                           logic [63:0] k3, logic [63:0] len);
        drain();
        cfg_write(CFG_KEY_12, k0);
        cfg_write(CFG_KEY_34, k1);
        cfg_write(CFG_KEY_56, k2);
        cfg_write(CFG_KEY_78, k3);
        cfg_write(CFG_KEY_LEN, len);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic test_reset_key();
        send_block(OP_ENCRYPT, '0, '0);
        send_block(OP_DECRYPT, '0, '0);
        send_block(OP_ENCRYPT, '1, '1);
        send_block(OP_DECRYPT, '1, '1);
    endtask

    task automatic test_key_lengths();
        for (int m = 0; m < 4; m++) begin
            set_key('1, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, '0, 64'(m));
            send_block(OP_ENCRYPT, 64'h8000_0000_0000_0001, 64'hFFFF_FFFF_0000_0000);
            send_block(OP_DECRYPT, 64'h5555_5555_AAAA_AAAA, 64'h0000_0001_8000_0000);
            send_block(OP_ENCRYPT, rand64(), rand64());
        end
    endtask

    task automatic test_ignored_writes();
        // 128-bit key with junk in the unused words, mode value with high bits set
        set_key(rand64(), rand64(), '1, '1, 64'hFFFF_FFFF_FFFF_FFFC);
        drain();
        cfg_write(CFG_SPARE_5, '1);
        cfg_write(CFG_SPARE_6, rand64());
        cfg_write(CFG_SPARE_7, '1);
        cfg_we <= 1'b0;
        send_block(OP_ENCRYPT, '1, '0);
        send_block(OP_DECRYPT, '0, '1);
        // 192-bit key: words seven and eight are derived, not read
        set_key(rand64(), rand64(), rand64(), '1, 64'h8000_0000_0000_0001);
        send_block(OP_ENCRYPT, rand64(), rand64());
        send_block(OP_DECRYPT, rand64(), rand64());
    endtask

    task automatic test_random_traffic(int unsigned phases, int unsigned per_phase);
        for (int p = 0; p < phases; p++) begin
            set_key(rand64(), rand64(), rand64(), rand64(), {$urandom, $urandom});
            for (int n = 0; n < per_phase; n++)
                send_block(logic'($urandom_range(0, 1)), rand64(), rand64());
        end
    endtask

    task automatic test_output_hold();
        bit saved;
        saved = idle_on;
        idle_on = 1'b0;
        in_valid <= 1'b0;
        @(negedge i_clk);
        hold_left = 300;
        @(posedge i_clk);
        // keep offering until the pipeline fills and pushes back
        for (int n = 0; n < 90; n++)
            send_block(logic'($urandom_range(0, 1)), rand64(), rand64());
        idle_on = saved;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_key();
        test_key_lengths();
        test_ignored_writes();
        idle_on = 1'b1;
        test_random_traffic(8, 32);
        test_output_hold();
        idle_on = 1'b0;
        test_random_traffic(2, 20);
        drain();
        $display("Sent %0d blocks, checked %0d results, across all key lengths,", blocks_sent,
                 blocks_seen);
        $display("both directions, ignored register writes and output back-pressure.");
        if (mismatches == 0 && cipher_fifo.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, cipher_fifo.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
